>>> rtl/adu_pkg.sv
// Shared constants, payload types and register codes for the Adadelta update block.
// No dependencies; every other file of the block but adu_stream_if imports this package.
package adu_pkg;

   localparam int unsigned ADU_STATE_DEPTH = 4096;
   localparam int unsigned ADU_INDEX_W     = 12;
   localparam int unsigned ADU_DATA_W      = 32;
   localparam int unsigned ADU_CSR_W       = 31;
   localparam int unsigned ADU_CSR_IDX_W   = 2;

   // latency of the root unit and of the divider, in register stages
   localparam int unsigned ADU_SQRT_LAT = 16;
   localparam int unsigned ADU_DIV_LAT  = 17;

   localparam logic [15:0] ADU_DECAY_RESET   = 16'd62259;
   localparam logic [15:0] ADU_EPS_RESET     = 16'd17;
   localparam logic [30:0] ADU_RATE_RESET    = 31'd16777216;

   typedef enum logic [1:0] {
      CSR_DECAY_RATE     = 2'd0,
      CSR_STABILITY_TERM = 2'd1,
      CSR_LEARNING_RATE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [11:0]        param_index;
      logic signed [31:0] gradient;
      logic signed [31:0] weight_in;
   } req_payload_type;

   typedef struct packed {
      logic [11:0]        param_index_out;
      logic signed [31:0] weight_out;
      logic signed [31:0] update_value;
      logic               saturated;
   } rsp_payload_type;

   // one pipeline slot; each stage fills the fields it owns and passes the rest on
   typedef struct packed {
      logic        valid;
      logic [11:0] idx;
      logic        gneg;
      logic [31:0] gmag;
      logic [31:0] w;
      logic [31:0] eg_old;
      logic [31:0] eu_old;
      logic [63:0] sq_full;
      logic [39:0] sq;
      logic [47:0] bl1;
      logic [56:0] bl2;
      logic [31:0] eg;
      logic [32:0] a;
      logic [32:0] b;
      logic [31:0] sa;
      logic [31:0] sb;
      logic        sbz;
      logic [63:0] gsa;
      logic [64:0] num;
      logic [32:0] den;
      logic [31:0] q;
      logic        ovf;
      logic [31:0] umag;
      logic [31:0] u;
      logic [62:0] prate;
      logic [38:0] p;
      logic [31:0] wout;
      logic [31:0] eu;
      logic        clip;
   } item_type;

endpackage

>>> rtl/adu_stream_if.sv
// Valid/ready stream channel used for requests and responses.
// Payload type comes from adu_pkg at the point of instantiation.
interface adu_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/adadelta_weight_update_top.sv
// Adadelta weight update, one parameter per request, fully pipelined: a new request can
// enter every cycle while no stall holds the pipeline. Five front stages square the
// gradient and blend the squared-gradient average. The two 16-stage square-root units run
// side by side and the 17-stage divider follows them. A few back stages finish the update,
// the weight and the squared-update average. Each address holds a mean squared gradient and
// a mean squared update in two on-chip memories. A request whose address matches any
// request still in flight waits at the input until that earlier one has written its
// averages back. So a run of one address waits for each write-back, while distinct
// addresses stream at full rate. After reset the memories are swept to zero, one
// entry per cycle through all STATE_DEPTH entries; no request is taken during the sweep, register
// writes are. Registers may be written only while the pipeline is empty. A stalled
// response holds the whole pipeline.
module adadelta_weight_update_top
   import adu_pkg::*;
#(
   parameter int unsigned STATE_DEPTH = ADU_STATE_DEPTH
)(
   input  logic                       clock,
   input  logic                       reset,
   adu_stream_if.sink                 req_ch,
   adu_stream_if.source               rsp_ch,
   input  logic                       csr_write_en,
   input  logic [ADU_CSR_IDX_W-1:0]   csr_index,
   input  logic [ADU_CSR_W-1:0]       csr_write_data
);

   localparam int unsigned AW  = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
   localparam int unsigned NST = 48;

   // stage numbers where each step lands
   localparam int unsigned ST_SQRT_IN = 5;
   localparam int unsigned ST_ROOT    = ST_SQRT_IN + ADU_SQRT_LAT + 1;
   localparam int unsigned ST_PROD    = ST_ROOT + 1;
   localparam int unsigned ST_DIV_IN  = ST_PROD + 1;
   localparam int unsigned ST_QUOT    = ST_DIV_IN + ADU_DIV_LAT + 1;
   localparam int unsigned ST_UPDATE  = ST_QUOT + 1;
   localparam int unsigned ST_SQ_U    = ST_UPDATE + 1;
   localparam int unsigned ST_RND_U   = ST_SQ_U + 1;
   localparam int unsigned ST_WEIGHT  = ST_RND_U + 1;
   localparam int unsigned ST_EU      = ST_WEIGHT + 1;

   // fold the request index into the state depth by subtracting shifted copies
   function automatic logic [11:0] reduce_index(input logic [11:0] raw);
      logic [11:0]     v;
      longint unsigned m;
      v = raw;
      for (int k = 11; k >= 0; k--) begin
         m = longint'(STATE_DEPTH) << k;
         if (m <= 64'd4095 && {52'd0, v} >= m) begin
            v = v - m[11:0];
         end
      end
      return v;
   endfunction

   function automatic logic [AW-1:0] to_addr(input logic [11:0] idx);
      logic [AW+11:0] wide;
      wide = {{AW{1'b0}}, idx};
      return wide[AW-1:0];
   endfunction

   // ---------------- configuration registers ----------------
   logic [15:0] decay_ff;
   logic [15:0] eps_ff;
   logic [30:0] rate_ff;
   logic [16:0] keep_c;   // 65536 - gamma

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= ADU_DECAY_RESET;
         eps_ff   <= ADU_EPS_RESET;
         rate_ff  <= ADU_RATE_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DECAY_RATE:     decay_ff <= csr_write_data[15:0];
            CSR_STABILITY_TERM: eps_ff   <= csr_write_data[15:0];
            CSR_LEARNING_RATE:  rate_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign keep_c = 17'h10000 - {1'b0, decay_ff};

   // ---------------- clearing sweep ----------------
   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == AW'(STATE_DEPTH - 1)) begin
            clr_active_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // ---------------- pipeline control ----------------
   item_type        pipe_ff [NST];
   item_type        pipe_in [NST];
   logic            advance;
   logic            req_fire;
   logic            wb_en;
   logic [11:0]     req_idx;
   logic [AW-1:0]   req_addr;
   logic [NST-1:0]  hit;
   logic [NST-1:0]  dup0;
   logic [NST-1:0]  valid_vec;

   assign req_idx  = reduce_index(req_ch.payload.param_index);
   assign req_addr = to_addr(req_idx);

   always_comb begin
      for (int k = 0; k < NST; k++) begin
         valid_vec[k] = pipe_ff[k].valid;
         hit[k]       = pipe_ff[k].valid && (pipe_ff[k].idx == req_idx);
         dup0[k]      = (k != 0) && pipe_ff[k].valid && (pipe_ff[k].idx == pipe_ff[0].idx);
      end
   end

   // hold everything while the response waits; hold a request whose address is in flight
   assign advance      = !pipe_ff[NST-1].valid || rsp_ch.ready;
   assign req_ch.ready = advance && !clr_active_ff && !(|hit);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign wb_en        = pipe_ff[NST-1].valid && advance;

   // ---------------- state memories ----------------
   logic [31:0]   eg_mem_ff [STATE_DEPTH];
   logic [31:0]   eu_mem_ff [STATE_DEPTH];
   logic [31:0]   eg_rd_ff;
   logic [31:0]   eu_rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [31:0]   mem_eg;
   logic [31:0]   mem_eu;

   assign mem_we   = clr_active_ff || wb_en;
   assign mem_addr = clr_active_ff ? clr_addr_ff : to_addr(pipe_ff[NST-1].idx);
   assign mem_eg   = clr_active_ff ? 32'd0 : pipe_ff[NST-1].eg;
   assign mem_eu   = clr_active_ff ? 32'd0 : pipe_ff[NST-1].eu;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         eg_mem_ff[mem_addr] <= mem_eg;
      end
      if (advance) begin
         eg_rd_ff <= eg_mem_ff[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         eu_mem_ff[mem_addr] <= mem_eu;
      end
      if (advance) begin
         eu_rd_ff <= eu_mem_ff[req_addr];
      end
   end

   // ---------------- shared units ----------------
   logic [31:0] root_a;
   logic [31:0] root_b;
   logic [31:0] div_q;
   logic        div_ovf;

   adu_sqrt_pipe u_sqrt_a (
      .clock    (clock),
      .advance  (advance),
      .radicand ({1'b0, pipe_ff[ST_SQRT_IN].a, 30'd0}),
      .root     (root_a)
   );

   adu_sqrt_pipe u_sqrt_b (
      .clock    (clock),
      .advance  (advance),
      .radicand ({1'b0, pipe_ff[ST_SQRT_IN].b, 30'd0}),
      .root     (root_b)
   );

   adu_div_pipe u_div (
      .clock   (clock),
      .advance (advance),
      .num     (pipe_ff[ST_DIV_IN].num),
      .den     (pipe_ff[ST_DIV_IN].den),
      .quot    (div_q),
      .ovf     (div_ovf)
   );

   // ---------------- stage logic ----------------
   always_comb begin
      logic [63:0]        rnd;
      logic [58:0]        acc;
      logic [42:0]        avg;
      logic [31:0]        mag;
      logic [62:0]        prnd;
      logic signed [40:0] wn;
      logic signed [40:0] wext;

      // entry: take the request, split the gradient into sign and magnitude
      pipe_in[0]       = pipe_ff[0];
      pipe_in[0].valid = req_fire;
      pipe_in[0].idx   = req_idx;
      pipe_in[0].gneg  = req_ch.payload.gradient[31];
      pipe_in[0].gmag  = req_ch.payload.gradient[31] ? 32'd0 - req_ch.payload.gradient
                                                      : req_ch.payload.gradient;
      pipe_in[0].w     = req_ch.payload.weight_in;
      pipe_in[0].clip  = 1'b0;

      for (int k = 1; k < NST; k++) begin
         pipe_in[k] = pipe_ff[k-1];
      end

      // square the gradient, pick up stored averages
      pipe_in[1].eg_old  = eg_rd_ff;
      pipe_in[1].eu_old  = eu_rd_ff;
      pipe_in[1].sq_full = pipe_ff[0].gmag * pipe_ff[0].gmag;

      // round the square, weight the old average
      rnd               = pipe_ff[1].sq_full + 64'd8388608;
      pipe_in[2].sq     = rnd[63:24];
      pipe_in[2].bl1    = pipe_ff[1].eg_old * decay_ff;

      pipe_in[3].bl2    = pipe_ff[2].sq * keep_c;

      // new squared-gradient average, clip to 32 bits
      acc = {11'd0, pipe_ff[3].bl1} + {2'd0, pipe_ff[3].bl2} + 59'd32768;
      avg = acc[58:16];
      if (avg > 43'h0FFFFFFFF) begin
         pipe_in[4].eg   = 32'hFFFFFFFF;
         pipe_in[4].clip = 1'b1;
      end else begin
         pipe_in[4].eg   = avg[31:0];
      end
      pipe_in[4].a = {1'b0, pipe_ff[3].eu_old} + {17'd0, eps_ff};

      pipe_in[ST_SQRT_IN].b = {1'b0, pipe_ff[ST_SQRT_IN-1].eg} + {17'd0, eps_ff};

      // roots come back
      pipe_in[ST_ROOT].sa = root_a;
      pipe_in[ST_ROOT].sb = root_b;

      pipe_in[ST_PROD].gsa = pipe_ff[ST_ROOT].gmag * pipe_ff[ST_ROOT].sa;
      pipe_in[ST_PROD].sbz = (pipe_ff[ST_ROOT].sb == 32'd0);

      // round-half-up quotient: (2*g*sA + sB) / (2*sB)
      pipe_in[ST_DIV_IN].num = {pipe_ff[ST_PROD].gsa, 1'b0} + {33'd0, pipe_ff[ST_PROD].sb};
      pipe_in[ST_DIV_IN].den = {pipe_ff[ST_PROD].sb, 1'b0};

      pipe_in[ST_QUOT].q   = div_q;
      pipe_in[ST_QUOT].ovf = div_ovf;

      // clamp the update magnitude, apply the sign
      if (pipe_ff[ST_QUOT].sbz) begin
         mag = 32'd0;
      end else if (pipe_ff[ST_QUOT].ovf) begin
         mag = 32'hFFFFFFFF;
      end else begin
         mag = pipe_ff[ST_QUOT].q;
      end
      if (pipe_ff[ST_QUOT].gneg) begin
         if (mag > 32'h80000000) begin
            mag                   = 32'h80000000;
            pipe_in[ST_UPDATE].clip = 1'b1;
         end
      end else if (mag > 32'h7FFFFFFF) begin
         mag                   = 32'h7FFFFFFF;
         pipe_in[ST_UPDATE].clip = 1'b1;
      end
      pipe_in[ST_UPDATE].umag = mag;
      pipe_in[ST_UPDATE].u    = pipe_ff[ST_QUOT].gneg ? 32'd0 - mag : mag;

      pipe_in[ST_SQ_U].sq_full = pipe_ff[ST_UPDATE].umag * pipe_ff[ST_UPDATE].umag;
      pipe_in[ST_SQ_U].prate   = pipe_ff[ST_UPDATE].umag * rate_ff;

      rnd                    = pipe_ff[ST_SQ_U].sq_full + 64'd8388608;
      pipe_in[ST_RND_U].sq   = rnd[63:24];
      prnd                   = pipe_ff[ST_SQ_U].prate + 63'd8388608;
      pipe_in[ST_RND_U].p    = prnd[62:24];
      pipe_in[ST_RND_U].bl1  = pipe_ff[ST_SQ_U].eu_old * decay_ff;

      // new weight, saturated
      pipe_in[ST_WEIGHT].bl2 = pipe_ff[ST_RND_U].sq * keep_c;
      wext = {{9{pipe_ff[ST_RND_U].w[31]}}, pipe_ff[ST_RND_U].w};
      if (pipe_ff[ST_RND_U].gneg) begin
         wn = wext + $signed({2'b00, pipe_ff[ST_RND_U].p});
      end else begin
         wn = wext - $signed({2'b00, pipe_ff[ST_RND_U].p});
      end
      if (wn > 41'sd2147483647) begin
         pipe_in[ST_WEIGHT].wout = 32'h7FFFFFFF;
         pipe_in[ST_WEIGHT].clip = 1'b1;
      end else if (wn < -41'sd2147483648) begin
         pipe_in[ST_WEIGHT].wout = 32'h80000000;
         pipe_in[ST_WEIGHT].clip = 1'b1;
      end else begin
         pipe_in[ST_WEIGHT].wout = wn[31:0];
      end

      // new squared-update average
      acc = {11'd0, pipe_ff[ST_WEIGHT].bl1} + {2'd0, pipe_ff[ST_WEIGHT].bl2} + 59'd32768;
      avg = acc[58:16];
      if (avg > 43'h0FFFFFFFF) begin
         pipe_in[ST_EU].eu   = 32'hFFFFFFFF;
         pipe_in[ST_EU].clip = 1'b1;
      end else begin
         pipe_in[ST_EU].eu   = avg[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   // ---------------- response ----------------
   assign rsp_ch.valid                   = pipe_ff[NST-1].valid;
   assign rsp_ch.payload.param_index_out = pipe_ff[NST-1].idx;
   assign rsp_ch.payload.weight_out      = pipe_ff[NST-1].wout;
   assign rsp_ch.payload.update_value    = pipe_ff[NST-1].u;
   assign rsp_ch.payload.saturated       = pipe_ff[NST-1].clip;

   // ---------------- assertions ----------------
   a_no_dup_in_flight: assert property (@(posedge clock) disable iff (reset)
      pipe_ff[0].valid |-> !(|dup0))
      else $error("two requests with one address in flight");

   a_empty_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !(|valid_vec))
      else $error("request in flight during memory sweep");

   a_no_wb_while_clearing: assert property (@(posedge clock) disable iff (reset)
      wb_en |-> !clr_active_ff)
      else $error("write-back collides with memory sweep");

   a_zero_den_zero_update: assert property (@(posedge clock) disable iff (reset)
      (pipe_ff[ST_UPDATE].valid && pipe_ff[ST_UPDATE].sbz) |-> (pipe_ff[ST_UPDATE].u == 32'd0))
      else $error("update not zero for zero denominator");

endmodule

>>> rtl/adu_sqrt_pipe.sv
// Pipelined integer square root: floor(sqrt(radicand)), two root bits per stage.
// Depends on adu_pkg for the stage count.
module adu_sqrt_pipe
   import adu_pkg::*;
(
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   localparam int unsigned NS = ADU_SQRT_LAT;

   logic [63:0] x_ff    [NS];
   logic [63:0] x_in    [NS];
   logic [33:0] rem_ff  [NS];
   logic [33:0] rem_in  [NS];
   logic [31:0] root_ff [NS];
   logic [31:0] root_in [NS];

   always_comb begin
      logic [63:0] x;
      logic [33:0] rm;
      logic [31:0] q;
      logic [35:0] sh;
      logic [33:0] t;
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            x  = radicand;
            rm = '0;
            q  = '0;
         end else begin
            x  = x_ff[s-1];
            rm = rem_ff[s-1];
            q  = root_ff[s-1];
         end
         for (int j = 0; j < 2; j++) begin
            sh = {rm, x[63:62]};
            t  = {q, 2'b01};
            if (sh >= {2'b00, t}) begin
               sh = sh - {2'b00, t};
               q  = {q[30:0], 1'b1};
            end else begin
               q  = {q[30:0], 1'b0};
            end
            rm = sh[33:0];
            x  = {x[61:0], 2'b00};
         end
         x_in[s]    = x;
         rem_in[s]  = rm;
         root_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff[NS-1];

endmodule

>>> rtl/adu_div_pipe.sv
// Pipelined unsigned divider: 65-bit dividend over 33-bit divisor, 32-bit quotient.
// Flags overflow when the quotient does not fit. Depends on adu_pkg.
module adu_div_pipe
   import adu_pkg::*;
(
   input  logic        clock,
   input  logic        advance,
   input  logic [64:0] num,
   input  logic [32:0] den,
   output logic [31:0] quot,
   output logic        ovf
);

   localparam int unsigned NS = ADU_DIV_LAT - 1;

   // front stage: split dividend, check overflow
   logic [32:0] pre_rem_ff;
   logic [31:0] pre_low_ff;
   logic [32:0] pre_den_ff;
   logic        pre_ovf_ff;

   logic [32:0] rem_ff [NS];
   logic [32:0] rem_in [NS];
   logic [31:0] low_ff [NS];
   logic [31:0] low_in [NS];
   logic [32:0] den_ff [NS];
   logic [32:0] den_in [NS];
   logic [31:0] q_ff   [NS];
   logic [31:0] q_in   [NS];
   logic        ovf_ff [NS];
   logic        ovf_in [NS];

   always_comb begin
      logic [32:0] rm;
      logic [31:0] lo;
      logic [31:0] q;
      logic [33:0] sh;
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            rm        = pre_rem_ff;
            lo        = pre_low_ff;
            q         = '0;
            den_in[s] = pre_den_ff;
            ovf_in[s] = pre_ovf_ff;
         end else begin
            rm        = rem_ff[s-1];
            lo        = low_ff[s-1];
            q         = q_ff[s-1];
            den_in[s] = den_ff[s-1];
            ovf_in[s] = ovf_ff[s-1];
         end
         for (int j = 0; j < 2; j++) begin
            sh = {rm, lo[31]};
            if (sh >= {1'b0, den_in[s]}) begin
               sh = sh - {1'b0, den_in[s]};
               q  = {q[30:0], 1'b1};
            end else begin
               q  = {q[30:0], 1'b0};
            end
            rm = sh[32:0];
            lo = {lo[30:0], 1'b0};
         end
         rem_in[s] = rm;
         low_in[s] = lo;
         q_in[s]   = q;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_rem_ff <= num[64:32];
         pre_low_ff <= num[31:0];
         pre_den_ff <= den;
         pre_ovf_ff <= (num[64:32] >= den);
         rem_ff     <= rem_in;
         low_ff     <= low_in;
         den_ff     <= den_in;
         q_ff       <= q_in;
         ovf_ff     <= ovf_in;
      end
   end

   assign quot = q_ff[NS-1];
   assign ovf  = ovf_ff[NS-1];

endmodule
